// File: rtl/hpt_pkg.sv
`default_nettype none
package hpt_pkg;

   localparam int DataWidth  = 32;
   localparam int FracBits   = 16;
   localparam int Entries    = 16;
   localparam int IndexWidth = 4;
   localparam int Lanes      = 3;
   localparam int AccWidth   = 2 * DataWidth + 2;
   localparam int NumWidth   = AccWidth + FracBits;
   localparam int QuoBits    = DataWidth;
   localparam int DshWidth   = AccWidth + QuoBits - 1;
   localparam int CmpWidth   = AccWidth + QuoBits;
   localparam int PlainWidth = AccWidth - FracBits;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_XFORM = 1'b1
   } func_type;

   typedef logic signed [DataWidth-1:0] data_type;
   typedef logic signed [AccWidth-1:0]  acc_type;

   localparam data_type DataMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam data_type DataMin = {1'b1, {(DataWidth-1){1'b0}}};
   localparam data_type OneF    = data_type'(1) <<< FracBits;
   localparam acc_type  OneW    = acc_type'(1) <<< (2 * FracBits);

   typedef struct packed {
      logic [NumWidth-1:0] rem;
      logic [QuoBits-1:0]  quo;
      logic                neg;
      logic                ovf;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [Lanes-1:0]  lane;
      logic [DshWidth-1:0]       dsh;
      logic                      divided;
      logic [Lanes-1:0][DataWidth-1:0] plain;
      logic [Lanes-1:0]          plain_sat;
   } div_item_type;

   function automatic data_type identity_entry(input logic [IndexWidth-1:0] idx);
      return (idx[1:0] == idx[3:2]) ? OneF : '0;
   endfunction

   // {saturated, value} of acc >>> FracBits clamped to the data range
   function automatic logic [DataWidth:0] fit_plain(input acc_type a);
      logic [PlainWidth-1:0] v;
      logic [PlainWidth-DataWidth:0] top;
      v   = a[AccWidth-1:FracBits];
      top = v[PlainWidth-1:DataWidth-1];
      if ((&top) || !(|top)) begin
         return {1'b0, v[DataWidth-1:0]};
      end else if (v[PlainWidth-1]) begin
         return {1'b1, DataMin};
      end else begin
         return {1'b1, DataMax};
      end
   endfunction

   // {saturated, value} of a signed quotient given as magnitude and sign
   function automatic logic [DataWidth:0] fit_quo(input div_lane_type l);
      logic big;
      big = l.ovf || (l.neg ? (l.quo > {1'b1, {(QuoBits-1){1'b0}}}) : l.quo[QuoBits-1]);
      if (big) begin
         return {1'b1, (l.neg ? DataMin : DataMax)};
      end else begin
         return {1'b0, (l.neg ? (~l.quo + 1'b1) : l.quo)};
      end
   endfunction

endpackage
`default_nettype wire

// File: rtl/hpt_front.sv
`default_nettype none
module hpt_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_func,
   input  wire [hpt_pkg::IndexWidth-1:0] req_entry_index,
   input  wire [hpt_pkg::DataWidth-1:0]  req_entry_value,
   input  wire [hpt_pkg::DataWidth-1:0]  req_point_x,
   input  wire [hpt_pkg::DataWidth-1:0]  req_point_y,
   input  wire [hpt_pkg::DataWidth-1:0]  req_point_z,
   output logic                         out_valid,
   input  wire                          out_ready,
   output hpt_pkg::div_item_type         out_item
);
   import hpt_pkg::*;

   data_type matrix_ff [Entries];
   data_type point [Lanes];

   logic                 valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic                 ready1, ready2, ready3, ready4;
   logic signed [2*DataWidth-1:0] prod_ff [4][Lanes];
   logic signed [2*DataWidth-1:0] prod_in [4][Lanes];
   data_type             trans_ff [4];
   acc_type              acc_ff [4];
   acc_type              acc_in [4];
   div_item_type         item3_ff, item3_in, item4_ff, item4_in;
   logic                 take;

   assign ready4    = !valid4_ff || out_ready;
   assign ready3    = !valid3_ff || ready4;
   assign ready2    = !valid2_ff || ready3;
   assign ready1    = !valid1_ff || ready2;
   assign req_stall = !ready1;
   assign take      = req_valid && ready1;

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < Lanes; c++) begin
            prod_in[r][c] = matrix_ff[r*4+c] * point[c];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         acc_in[r] = AccWidth'(prod_ff[r][0]) + AccWidth'(prod_ff[r][1])
                   + AccWidth'(prod_ff[r][2]) + (AccWidth'(trans_ff[r]) <<< FracBits);
      end
   end

   always_comb begin
      logic [AccWidth-1:0]  dmag;
      logic [AccWidth-1:0]  nmag;
      logic [DataWidth:0]   pf;
      item3_in = '0;
      dmag = acc_ff[3][AccWidth-1] ? (~acc_ff[3] + 1'b1) : acc_ff[3];
      item3_in.divided = (acc_ff[3] != '0) && (acc_ff[3] != OneW);
      item3_in.dsh     = {dmag, {(QuoBits-1){1'b0}}};
      for (int l = 0; l < Lanes; l++) begin
         nmag = acc_ff[l][AccWidth-1] ? (~acc_ff[l] + 1'b1) : acc_ff[l];
         item3_in.lane[l].rem = {nmag, {FracBits{1'b0}}};
         item3_in.lane[l].neg = acc_ff[l][AccWidth-1] ^ acc_ff[3][AccWidth-1];
         pf = fit_plain(acc_ff[l]);
         item3_in.plain[l]     = pf[DataWidth-1:0];
         item3_in.plain_sat[l] = pf[DataWidth];
      end
   end

   always_comb begin
      item4_in = item3_ff;
      for (int l = 0; l < Lanes; l++) begin
         item4_in.lane[l].ovf = CmpWidth'(item3_ff.lane[l].rem) >= {item3_ff.dsh, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Entries; i++) begin
            matrix_ff[i] <= identity_entry(IndexWidth'(i));
         end
      end else if (take && req_func == FUNC_WRITE) begin
         matrix_ff[req_entry_index] <= req_entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= take && req_func == FUNC_XFORM;
         if (ready2) valid2_ff <= valid1_ff;
         if (ready3) valid3_ff <= valid2_ff;
         if (ready4) valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         prod_ff <= prod_in;
         for (int r = 0; r < 4; r++) begin
            trans_ff[r] <= matrix_ff[r*4+3];
         end
      end
      if (ready2) acc_ff <= acc_in;
      if (ready3) item3_ff <= item3_in;
      if (ready4) item4_ff <= item4_in;
   end

   assign out_valid = valid4_ff;
   assign out_item  = item4_ff;

endmodule
`default_nettype wire

// File: rtl/hpt_div_step.sv
`default_nettype none
module hpt_div_step (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  hpt_pkg::div_item_type in_item,
   output logic                  out_valid,
   input  wire                   out_ready,
   output hpt_pkg::div_item_type out_item
);
   import hpt_pkg::*;

   logic         valid_ff;
   div_item_type item_ff, item_in;

   assign in_ready = !valid_ff || out_ready;

   // one restoring step per lane against the shared shifted divisor
   always_comb begin
      item_in = in_item;
      for (int l = 0; l < Lanes; l++) begin
         if (DshWidth'(in_item.lane[l].rem) >= in_item.dsh) begin
            item_in.lane[l].rem = in_item.lane[l].rem - in_item.dsh[NumWidth-1:0];
            item_in.lane[l].quo = {in_item.lane[l].quo[QuoBits-2:0], 1'b1};
         end else begin
            item_in.lane[l].quo = {in_item.lane[l].quo[QuoBits-2:0], 1'b0};
         end
      end
      item_in.dsh = in_item.dsh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// File: rtl/homogeneous_point_transform_unit.sv
// Homogeneous point transform unit.
// Request channel (req_valid / req_stall): req_func selects a matrix write
// (req_entry_index, req_entry_value) or a point transform (req_point_x/y/z).
// A write updates the 4x4 Q16.16 matrix at acceptance and gives no response;
// later transforms see it, earlier ones in flight do not.
// Response channel (rsp_valid / rsp_stall): one response per transform with
// rsp_out_x/y/z, rsp_divided (divide by w applied) and rsp_saturated.
// From request acceptance to rsp_valid, a transform passes multiply,
// accumulate, sign/magnitude, range check, 32 divide steps, output register.
// Throughput: one request per cycle unless stalled; the 32-step divider is
// restoring and fully pipelined, one quotient bit per stage for x, y and z.
// Reset clears all valid bits and loads the identity matrix.
// When rsp_stall is high the pipeline compresses bubbles and keeps taking
// requests until every stage is full, then raises req_stall.
`default_nettype none
module homogeneous_point_transform_unit (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire                           req_func,
   input  wire [hpt_pkg::IndexWidth-1:0] req_entry_index,
   input  wire [hpt_pkg::DataWidth-1:0]  req_entry_value,
   input  wire [hpt_pkg::DataWidth-1:0]  req_point_x,
   input  wire [hpt_pkg::DataWidth-1:0]  req_point_y,
   input  wire [hpt_pkg::DataWidth-1:0]  req_point_z,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [hpt_pkg::DataWidth-1:0] rsp_out_x,
   output logic [hpt_pkg::DataWidth-1:0] rsp_out_y,
   output logic [hpt_pkg::DataWidth-1:0] rsp_out_z,
   output logic                          rsp_divided,
   output logic                          rsp_saturated
);
   import hpt_pkg::*;

   logic         stage_valid [QuoBits+1];
   logic         stage_ready [QuoBits+1];
   div_item_type stage_item  [QuoBits+1];

   logic                 rsp_valid_ff;
   logic                 last_ready;
   logic [Lanes-1:0][DataWidth-1:0] res_ff, res_in;
   logic                 div_ff, div_in, sat_ff, sat_in;

   hpt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .out_valid       (stage_valid[0]),
      .out_ready       (stage_ready[0]),
      .out_item        (stage_item[0])
   );

   for (genvar i = 0; i < QuoBits; i++) begin : g_div
      hpt_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_item   (stage_item[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_item  (stage_item[i+1])
      );
   end

   assign last_ready            = !rsp_valid_ff || !rsp_stall;
   assign stage_ready[QuoBits]  = last_ready;

   always_comb begin
      logic [DataWidth:0] f;
      div_in = stage_item[QuoBits].divided;
      sat_in = 1'b0;
      for (int l = 0; l < Lanes; l++) begin
         if (div_in) begin
            f = fit_quo(stage_item[QuoBits].lane[l]);
         end else begin
            f = {stage_item[QuoBits].plain_sat[l], stage_item[QuoBits].plain[l]};
         end
         res_in[l] = f[DataWidth-1:0];
         sat_in    = sat_in | f[DataWidth];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_ready) begin
         rsp_valid_ff <= stage_valid[QuoBits];
      end
   end

   always_ff @(posedge clock) begin
      if (last_ready) begin
         res_ff <= res_in;
         div_ff <= div_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = res_ff[0];
   assign rsp_out_y     = res_ff[1];
   assign rsp_out_z     = res_ff[2];
   assign rsp_divided   = div_ff;
   assign rsp_saturated = sat_ff;

   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_sat_clamps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_out_x == DataMax || rsp_out_x == DataMin ||
          rsp_out_y == DataMax || rsp_out_y == DataMin ||
          rsp_out_z == DataMax || rsp_out_z == DataMin))
      else $error("saturated flag without a clamped coordinate");

endmodule
`default_nettype wire

// File: bench/homogeneous_point_transform_unit_test.sv
`timescale 1ns / 100ps
module homogeneous_point_transform_unit_test;
   import hpt_pkg::*;

   localparam int CycleLimit = 300000;
   localparam int DrainCycles = 60;
   localparam int RandomRequests = 450;
   localparam data_type One = OneF;

   typedef logic signed [127:0] exact_type;

   typedef struct {
      data_type x;
      data_type y;
      data_type z;
      logic     divided;
      logic     saturated;
   } point_result_type;

   typedef struct {
      func_type         func;
      logic [3:0]       index;
      data_type         value;
      data_type         x;
      data_type         y;
      data_type         z;
      bit               typed;
      point_result_type result;
   } stimulus_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_func = FUNC_WRITE;
   logic [IndexWidth-1:0] req_entry_index = '0;
   logic [DataWidth-1:0] req_entry_value = '0;
   logic [DataWidth-1:0] req_point_x = '0;
   logic [DataWidth-1:0] req_point_y = '0;
   logic [DataWidth-1:0] req_point_z = '0;
   logic rsp_stall = 0;
   wire req_stall;
   wire rsp_valid;
   wire [DataWidth-1:0] rsp_out_x;
   wire [DataWidth-1:0] rsp_out_y;
   wire [DataWidth-1:0] rsp_out_z;
   wire rsp_divided;
   wire rsp_saturated;

   data_type matrix [Entries];
   point_result_type pending_results [$];
   stimulus_row_type rows [$];
   int failures = 0;
   int cycles = 0;
   int stall_mode = 0;

   homogeneous_point_transform_unit uut (.*);

   always #5 clock = ~clock;

   function automatic data_type clamp(input exact_type v, inout logic sat);
      if (v > exact_type'(DataMax)) begin
         sat = 1;
         return DataMax;
      end else if (v < exact_type'(DataMin)) begin
         sat = 1;
         return DataMin;
      end
      return data_type'(v);
   endfunction

   function automatic point_result_type transform_point(input data_type x, input data_type y,
                                                        input data_type z);
      exact_type acc [4];
      exact_type v;
      data_type coords [3];
      point_result_type res;
      logic sat;
      sat = 0;
      for (int r = 0; r < 4; r++) begin
         acc[r] = (exact_type'(matrix[r*4+3]) <<< FracBits)
                + exact_type'(matrix[r*4]) * exact_type'(x)
                + exact_type'(matrix[r*4+1]) * exact_type'(y)
                + exact_type'(matrix[r*4+2]) * exact_type'(z);
      end
      res.divided = (acc[3] != 0) && (acc[3] != (exact_type'(1) <<< (2*FracBits)));
      for (int r = 0; r < 3; r++) begin
         if (res.divided) v = (acc[r] <<< FracBits) / acc[3];
         else v = acc[r] >>> FracBits;
         coords[r] = clamp(v, sat);
      end
      res.x = coords[0];
      res.y = coords[1];
      res.z = coords[2];
      res.saturated = sat;
      return res;
   endfunction

   function automatic data_type random_word();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? DataMax : DataMin;
         2: return data_type'($signed($urandom_range(0, 2*One)) - One);
         default: return data_type'($signed($urandom_range(0, 8*One)) - 4*One);
      endcase
   endfunction

   task automatic add_row(input func_type f, input int index, input data_type value,
                          input data_type x, input data_type y, input data_type z,
                          input bit typed = 0, input point_result_type result = '{0, 0, 0, 0, 0});
      stimulus_row_type row;
      row.func = f;
      row.index = IndexWidth'(index);
      row.value = value;
      row.x = x;
      row.y = y;
      row.z = z;
      row.typed = typed;
      row.result = result;
      rows.push_back(row);
   endtask

   task automatic issue_request(input stimulus_row_type row);
      req_valid <= 1;
      req_func <= row.func;
      req_entry_index <= row.index;
      req_entry_value <= row.value;
      req_point_x <= row.x;
      req_point_y <= row.y;
      req_point_z <= row.z;
      do @(posedge clock); while (req_stall);
      if (row.func == FUNC_WRITE) begin
         matrix[row.index] = row.value;
      end else if (row.typed) begin
         pending_results.push_back(row.result);
      end else begin
         pending_results.push_back(transform_point(row.x, row.y, row.z));
      end
   endtask

   task automatic send_with_gap(input stimulus_row_type row);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      issue_request(row);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("homogeneous_point_transform_unit verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= (cycles % 16) < 9;
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            failures = failures + 1;
         end else begin
            point_result_type e;
            e = pending_results.pop_front();
            if (rsp_out_x !== e.x) begin
               $error("out_x expected %h got %h", e.x, rsp_out_x);
               failures = failures + 1;
            end
            if (rsp_out_y !== e.y) begin
               $error("out_y expected %h got %h", e.y, rsp_out_y);
               failures = failures + 1;
            end
            if (rsp_out_z !== e.z) begin
               $error("out_z expected %h got %h", e.z, rsp_out_z);
               failures = failures + 1;
            end
            if (rsp_divided !== e.divided) begin
               $error("divided expected %b got %b", e.divided, rsp_divided);
               failures = failures + 1;
            end
            if (rsp_saturated !== e.saturated) begin
               $error("saturated expected %b got %b", e.saturated, rsp_saturated);
               failures = failures + 1;
            end
         end
      end
   end

   initial begin
      stimulus_row_type row;
      for (int i = 0; i < Entries; i++) matrix[i] = (i % 5 == 0) ? One : '0;

      // identity after reset, extremes, overflow both ways, w = 0, w = 2.0
      add_row(FUNC_XFORM, 0, 0, One, 2*One, 3*One, 1, '{One, 2*One, 3*One, 0, 0});
      add_row(FUNC_XFORM, 0, 0, DataMax, DataMin, 0, 1, '{DataMax, DataMin, 0, 0, 0});
      add_row(FUNC_XFORM, 0, 0, -1, -1, -1, 1, '{-1, -1, -1, 0, 0});
      add_row(FUNC_XFORM, 15, DataMax, 32'h12345678, 32'h80000001, DataMax, 1,
              '{32'h12345678, 32'h80000001, DataMax, 0, 0});
      add_row(FUNC_WRITE, 0, DataMax, 0, 0, 0);
      add_row(FUNC_XFORM, 0, 0, DataMax, 0, 0, 1, '{DataMax, 0, 0, 0, 1});
      add_row(FUNC_WRITE, 0, DataMin, 0, 0, 0);
      add_row(FUNC_XFORM, 0, 0, DataMax, 0, 0, 1, '{DataMin, 0, 0, 0, 1});
      add_row(FUNC_WRITE, 0, One, DataMax, DataMin, -1);
      add_row(FUNC_WRITE, 15, 0, 0, 0, 0);
      add_row(FUNC_XFORM, 0, 0, One, 2*One, 3*One, 1, '{One, 2*One, 3*One, 0, 0});
      add_row(FUNC_WRITE, 15, 2*One, 0, 0, 0);
      add_row(FUNC_XFORM, 0, 0, 2*One, 4*One, -6*One, 1, '{One, 2*One, -3*One, 1, 0});
      add_row(FUNC_WRITE, 12, One, 0, 0, 0);
      add_row(FUNC_XFORM, 4, DataMin, 3*One, One, One);
      add_row(FUNC_WRITE, 12, 0, 0, 0, 0);
      add_row(FUNC_WRITE, 14, -One, 0, 0, 0);
      add_row(FUNC_WRITE, 15, One, 0, 0, 0);
      add_row(FUNC_XFORM, 0, 0, 0, 0, One);
      add_row(FUNC_XFORM, 0, 0, 5*One, -5*One, 2*One);
      add_row(FUNC_WRITE, 14, 0, 0, 0, 0);
      add_row(FUNC_WRITE, 15, 1, 0, 0, 0);
      add_row(FUNC_XFORM, 0, 0, One, -One, One);
      add_row(FUNC_WRITE, 15, One, 0, 0, 0);
      add_row(FUNC_WRITE, 3, DataMax, 0, 0, 0);
      add_row(FUNC_XFORM, 0, 0, 0, 0, 0);

      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) send_with_gap(rows[i]);

      for (int n = 0; n < RandomRequests; n++) begin
         if ($urandom_range(0, 24) == 0) begin
            // put the w row back so undivided results keep coming
            for (int i = 12; i < 16; i++) begin
               row.func = FUNC_WRITE;
               row.index = IndexWidth'(i);
               row.value = (i == 15) ? ($urandom_range(0, 3) == 0 ? '0 : One) : '0;
               row.typed = 0;
               {row.x, row.y, row.z} = {$urandom(), $urandom(), $urandom()};
               send_with_gap(row);
            end
         end
         row.func = ($urandom_range(0, 9) < 2) ? FUNC_WRITE : FUNC_XFORM;
         row.index = IndexWidth'($urandom_range(0, 15));
         row.value = random_word();
         row.x = random_word();
         row.y = random_word();
         row.z = random_word();
         row.typed = 0;
         send_with_gap(row);
      end
      req_valid <= 0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (failures == 0) begin
         $display("homogeneous_point_transform_unit verification clean");
      end else begin
         $display("homogeneous_point_transform_unit verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/hpt_pkg.sv
rtl/hpt_front.sv
rtl/hpt_div_step.sv
rtl/homogeneous_point_transform_unit.sv
bench/homogeneous_point_transform_unit_test.sv
